@@ src/fixed_frame_command_decoder_core_defines.svh @@
// assertion macros for the fixed frame command decoder
// no dependencies; included by the top level before its assertions
`ifndef FIXED_FRAME_COMMAND_DECODER_CORE_DEFINES_SVH
`define FIXED_FRAME_COMMAND_DECODER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define FCD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define FCD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/fcd_pkg.sv @@
// shared types, constants and helper functions for the fixed frame command decoder
// no dependencies
`timescale 1ns / 1ps

package fcd_pkg;

  localparam int FRAME_LEN = 9;
  localparam int STORE_DEPTH = FRAME_LEN - 1;
  localparam int CNT_W = 4;
  localparam int IDX_W = $clog2(STORE_DEPTH);

  localparam logic [7:0] HDR_BYTE  = 8'h00;
  localparam logic [7:0] TRL_BYTE  = 8'hEF;
  localparam logic [7:0] CMD_CODE  = 8'h0A;
  localparam logic [7:0] CMD_COORD = 8'h0C;
  localparam logic [7:0] CMD_GRAB  = 8'h0D;
  localparam logic [7:0] GRAB_OK   = 8'h02;
  localparam logic [7:0] SIGN_POS  = 8'h0A;

  localparam int DIGIT_W = 6;
  localparam int COORD_W = 13;

  typedef enum logic [2:0] {
    KIND_CODE    = 3'd0,
    KIND_COORD   = 3'd1,
    KIND_GRAB_OK = 3'd2,
    KIND_GRAB_OTHER = 3'd3,
    KIND_UNKNOWN = 3'd4
  } kind_t;

  // ascii code of the leading decimal digit, zero gives '0'
  function automatic logic [DIGIT_W-1:0] lead_digit(input logic [7:0] v);
    logic [3:0] d;
    case (v) inside
      [8'd200:8'd255]: d = 4'd2;
      [8'd100:8'd199]: d = 4'd1;
      [8'd90:8'd99]:   d = 4'd9;
      [8'd80:8'd89]:   d = 4'd8;
      [8'd70:8'd79]:   d = 4'd7;
      [8'd60:8'd69]:   d = 4'd6;
      [8'd50:8'd59]:   d = 4'd5;
      [8'd40:8'd49]:   d = 4'd4;
      [8'd30:8'd39]:   d = 4'd3;
      [8'd20:8'd29]:   d = 4'd2;
      [8'd10:8'd19]:   d = 4'd1;
      default:         d = v[3:0];
    endcase
    return DIGIT_W'(6'd48 + {2'b00, d});
  endfunction

  // (hi << 4) | lo, negated unless the sign byte is the positive mark
  function automatic logic [COORD_W-1:0] coord_field(input logic [7:0] sign,
                                                     input logic [7:0] hi,
                                                     input logic [7:0] lo);
    logic [COORD_W-1:0] v;
    v = {1'b0, hi, 4'b0000} | {5'b00000, lo};
    if (sign != SIGN_POS) begin
      v = COORD_W'(0) - v;
    end
    return v;
  endfunction

endpackage

@@ src/fixed_frame_command_decoder_core.sv @@
// top level of the fixed frame command decoder: byte gathering, frame check, result register
// depends on fcd_pkg and fixed_frame_command_decoder_core_defines.svh
`timescale 1ns / 1ps
`include "fixed_frame_command_decoder_core_defines.svh"

// Takes one received byte per beat and counts them into 9-byte frames with
// no resynchronization. Bytes 0 to 7 go into a small frame register; when the
// ninth byte is taken, the header (byte 0 = 0x00) and trailer (0xEF) are
// checked and a good frame is decoded by its command byte in the same cycle
// into the result register, which shows it on the next cycle. A bad frame is
// dropped with no result. Throughput is one byte per clock: in_ready drops
// only for the ninth byte of a frame while the result register still holds a
// result that has not been taken.
module fixed_frame_command_decoder_core
  import fcd_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                rx_byte,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [2:0]                frame_kind,
  output logic [DIGIT_W-1:0]        digit_a0,
  output logic [DIGIT_W-1:0]        digit_a1,
  output logic [DIGIT_W-1:0]        digit_a2,
  output logic [DIGIT_W-1:0]        digit_b0,
  output logic [DIGIT_W-1:0]        digit_b1,
  output logic [DIGIT_W-1:0]        digit_b2,
  output logic signed [COORD_W-1:0] coord_x,
  output logic signed [COORD_W-1:0] coord_y
);

  logic [CNT_W-1:0]   byte_count;
  logic [CNT_W-1:0]   byte_count_next;
  logic [7:0]         frame_bytes [STORE_DEPTH];
  logic               last_byte;
  logic               in_fire;
  logic               frame_ok;
  logic               load_result;
  logic               out_valid_next;

  kind_t              kind_c;
  logic [DIGIT_W-1:0] digit_c [6];
  logic [COORD_W-1:0] coord_x_c;
  logic [COORD_W-1:0] coord_y_c;

  // an out of range count also ends the frame
  assign last_byte = (byte_count >= CNT_W'(FRAME_LEN - 1));
  assign in_ready  = !last_byte || !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign frame_ok  = (frame_bytes[0] == HDR_BYTE) && (rx_byte == TRL_BYTE);
  assign load_result = in_fire && last_byte && frame_ok;

  always_comb begin
    byte_count_next = byte_count;
    if (in_fire) begin
      byte_count_next = last_byte ? '0 : byte_count + CNT_W'(1);
    end
  end

  assign out_valid_next = load_result || (out_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      byte_count <= byte_count_next;
      out_valid  <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !last_byte) begin
      frame_bytes[byte_count[IDX_W-1:0]] <= rx_byte;
    end
  end

  // decode by command byte, unused fields stay zero
  always_comb begin
    kind_c    = KIND_UNKNOWN;
    coord_x_c = '0;
    coord_y_c = '0;
    for (int i = 0; i < 6; i++) begin
      digit_c[i] = '0;
    end
    case (frame_bytes[1])
      CMD_CODE: begin
        kind_c = KIND_CODE;
        for (int i = 0; i < 6; i++) begin
          digit_c[i] = lead_digit(frame_bytes[i + 2]);
        end
      end
      CMD_COORD: begin
        kind_c    = KIND_COORD;
        coord_x_c = coord_field(frame_bytes[2], frame_bytes[3], frame_bytes[4]);
        coord_y_c = coord_field(frame_bytes[5], frame_bytes[6], frame_bytes[7]);
      end
      CMD_GRAB: begin
        kind_c = (frame_bytes[2] == GRAB_OK) ? KIND_GRAB_OK : KIND_GRAB_OTHER;
      end
      default: begin
        kind_c = KIND_UNKNOWN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_result) begin
      frame_kind <= kind_c;
      digit_a0   <= digit_c[0];
      digit_a1   <= digit_c[1];
      digit_a2   <= digit_c[2];
      digit_b0   <= digit_c[3];
      digit_b1   <= digit_c[4];
      digit_b2   <= digit_c[5];
      coord_x    <= coord_x_c;
      coord_y    <= coord_y_c;
    end
  end

  `FCD_ASSERT_NOW(a_count_range, clk, rst, 1'b1,
                  byte_count <= CNT_W'(FRAME_LEN - 1),
                  "byte count beyond frame length")
  `FCD_ASSERT_NEXT(a_count_wrap, clk, rst, in_fire && last_byte,
                   byte_count == '0,
                   "count did not restart after last byte")
  `FCD_ASSERT_NEXT(a_no_early_result, clk, rst, in_fire && !last_byte,
                   out_valid == $past(out_valid && !out_ready),
                   "result raised before frame end")
  `FCD_ASSERT_NOW(a_coord_zero, clk, rst, out_valid && frame_kind != KIND_COORD,
                  coord_x == '0 && coord_y == '0,
                  "coordinates set outside coordinate result")

endmodule

@@ test/fixed_frame_command_decoder_core_tb.sv @@
// self-checking bench for the fixed frame command decoder: directed and random byte streams
// with bursty sending and receiver stalls, every result checked against a local frame decoder
// depends on fcd_pkg and fixed_frame_command_decoder_core
`timescale 1ns / 1ps

module fixed_frame_command_decoder_core_tb;
  import fcd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;

  typedef struct packed {
    kind_t                    kind;
    logic [5:0][DIGIT_W-1:0]  digits;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
  } frame_result_t;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [7:0]                rx_byte = 8'd0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [2:0]                frame_kind;
  logic [DIGIT_W-1:0]        digit_a0, digit_a1, digit_a2;
  logic [DIGIT_W-1:0]        digit_b0, digit_b1, digit_b2;
  logic signed [COORD_W-1:0] coord_x, coord_y;

  fixed_frame_command_decoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .frame_kind (frame_kind),
    .digit_a0   (digit_a0),
    .digit_a1   (digit_a1),
    .digit_a2   (digit_a2),
    .digit_b0   (digit_b0),
    .digit_b1   (digit_b1),
    .digit_b2   (digit_b2),
    .coord_x    (coord_x),
    .coord_y    (coord_y)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // local copy of the frame gatherer
  logic [7:0]    frame_store [STORE_DEPTH];
  logic [3:0]    frame_fill;

  logic [7:0]    pending_bytes [$];
  frame_result_t frame_results_due [$];

  int error_count = 0;
  int bytes_accepted = 0;
  int cycle_count = 0;
  int kind_hits [5] = '{default: 0};
  int burst_left = 0;
  int gap_left = 0;

  task automatic flag_error(input string msg);
    if (error_count < 50) $display("error at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic logic [DIGIT_W-1:0] ascii_lead(input logic [7:0] v);
    int d;
    if (v >= 100) d = v / 100;
    else if (v >= 10) d = v / 10;
    else d = v;
    return DIGIT_W'(48 + d);
  endfunction

  function automatic logic [COORD_W-1:0] signed_coord(input logic [7:0] sign,
                                                      input logic [7:0] hi,
                                                      input logic [7:0] lo);
    int v;
    v = (int'(hi) << 4) | int'(lo);
    if (sign != SIGN_POS) v = -v;
    return COORD_W'(v);
  endfunction

  function automatic void clear_frame();
    for (int i = 0; i < STORE_DEPTH; i++) frame_store[i] = 8'd0;
    frame_fill = 4'd0;
  endfunction

  // takes one accepted byte, returns 1 when it closes a good frame
  function automatic bit decode_byte(input logic [7:0] b, output frame_result_t res);
    res = '0;
    if (frame_fill < 4'(FRAME_LEN - 1)) begin
      frame_store[frame_fill[IDX_W-1:0]] = b;
      frame_fill = frame_fill + 4'd1;
      return 1'b0;
    end
    if (frame_store[0] != HDR_BYTE || b != TRL_BYTE) begin
      clear_frame();
      return 1'b0;
    end
    case (frame_store[1])
      CMD_CODE: begin
        res.kind = KIND_CODE;
        for (int j = 0; j < 6; j++) res.digits[j] = ascii_lead(frame_store[2 + j]);
      end
      CMD_COORD: begin
        res.kind = KIND_COORD;
        res.x = signed_coord(frame_store[2], frame_store[3], frame_store[4]);
        res.y = signed_coord(frame_store[5], frame_store[6], frame_store[7]);
      end
      CMD_GRAB: res.kind = (frame_store[2] == GRAB_OK) ? KIND_GRAB_OK : KIND_GRAB_OTHER;
      default: res.kind = KIND_UNKNOWN;
    endcase
    clear_frame();
    return 1'b1;
  endfunction

  function automatic logic [7:0] pick_byte();
    logic [7:0] edges [8] = '{8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd199, 8'd200, 8'd255};
    if ($urandom_range(0, 3) == 0) return edges[$urandom_range(0, 7)];
    return 8'($urandom);
  endfunction

  task automatic queue_frame(input logic [7:0] fb [FRAME_LEN]);
    for (int i = 0; i < FRAME_LEN; i++) pending_bytes.push_back(fb[i]);
  endtask

  // mostly well-formed frames with random content, some bad and some junk
  task automatic make_frame(output logic [7:0] fb [FRAME_LEN]);
    logic [7:0] cmds [3] = '{CMD_CODE, CMD_COORD, CMD_GRAB};
    int sel;
    sel = $urandom_range(0, 9);
    for (int i = 0; i < FRAME_LEN; i++) fb[i] = pick_byte();
    fb[0] = HDR_BYTE;
    fb[FRAME_LEN-1] = TRL_BYTE;
    case (sel)
      0, 1: fb[1] = CMD_CODE;
      2, 3: begin
        fb[1] = CMD_COORD;
        if ($urandom_range(0, 1) == 1) fb[2] = SIGN_POS;
        if ($urandom_range(0, 1) == 1) fb[5] = SIGN_POS;
      end
      4, 5: begin
        fb[1] = CMD_GRAB;
        if ($urandom_range(0, 1) == 1) fb[2] = GRAB_OK;
      end
      6: begin
        do fb[1] = 8'($urandom);
        while (fb[1] == CMD_CODE || fb[1] == CMD_COORD || fb[1] == CMD_GRAB);
      end
      7: begin
        fb[1] = cmds[$urandom_range(0, 2)];
        while (fb[0] == HDR_BYTE) fb[0] = pick_byte();
      end
      8: begin
        fb[1] = cmds[$urandom_range(0, 2)];
        while (fb[FRAME_LEN-1] == TRL_BYTE) fb[FRAME_LEN-1] = pick_byte();
      end
      default: begin
        fb[0] = 8'($urandom);
        fb[FRAME_LEN-1] = 8'($urandom);
      end
    endcase
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || in_valid || frame_results_due.size() != 0)
      @(negedge clk);
  endtask

  // sender: bursts of random length with random gaps
  always @(posedge clk) begin : drive_proc
    frame_result_t res;
    if (rst) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'd0;
    end else begin
      if (in_valid && in_ready) begin
        bytes_accepted++;
        if (decode_byte(rx_byte, res)) frame_results_due.push_back(res);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0 || pending_bytes.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          rx_byte  <= pending_bytes.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // receiver: rotating stall pattern, one long hold after a dozen results
  logic [15:0] stall_pattern = 16'hFFFF;
  int pattern_age = 0;
  int hold_left = 0;
  int beats_taken = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) beats_taken++;
      if (!hold_done && beats_taken >= 12) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        if (pattern_age == 0) begin
          pattern_age = 64;
          stall_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        end
        pattern_age--;
        out_ready <= stall_pattern[0];
        stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
    end
  end

  // monitor: each result beat against the oldest predicted frame
  always @(posedge clk) begin : check_proc
    frame_result_t           want;
    logic [5:0][DIGIT_W-1:0] got_digits;
    if (!rst && out_valid && out_ready) begin
      got_digits = {digit_b2, digit_b1, digit_b0, digit_a2, digit_a1, digit_a0};
      if (frame_results_due.size() == 0) begin
        flag_error($sformatf("result with none pending, kind %0d", frame_kind));
      end else begin
        want = frame_results_due.pop_front();
        if (frame_kind !== want.kind)
          flag_error($sformatf("frame_kind %0d, wanted %0d", frame_kind, want.kind));
        for (int i = 0; i < 6; i++)
          if (got_digits[i] !== want.digits[i])
            flag_error($sformatf("digit %0d is %0d, wanted %0d", i, got_digits[i],
                                 want.digits[i]));
        if (coord_x !== want.x)
          flag_error($sformatf("coord_x %0d, wanted %0d", coord_x, $signed(want.x)));
        if (coord_y !== want.y)
          flag_error($sformatf("coord_y %0d, wanted %0d", coord_y, $signed(want.y)));
      end
      if (frame_kind < 3'd5) kind_hits[frame_kind]++;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    logic [7:0] fb [FRAME_LEN];
    int random_bytes;
    clear_frame();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // digits at the decade edges, coordinates at both extremes, grab done
    fb = '{HDR_BYTE, CMD_CODE, 8'd0, 8'd9, 8'd10, 8'd99, 8'd100, 8'd255, TRL_BYTE};
    queue_frame(fb);
    fb = '{HDR_BYTE, CMD_COORD, SIGN_POS, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF, TRL_BYTE};
    queue_frame(fb);
    fb = '{HDR_BYTE, CMD_GRAB, GRAB_OK, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, TRL_BYTE};
    queue_frame(fb);
    wait_drained();

    random_bytes = 0;
    for (int phase = 0; phase < 2; phase++) begin
      while (random_bytes < 200 * (phase + 1)) begin
        make_frame(fb);
        queue_frame(fb);
        random_bytes += FRAME_LEN;
      end
      // sender stays quiet until every pending result is out
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (frame_results_due.size() != 0)
      flag_error($sformatf("%0d results never arrived", frame_results_due.size()));

    $display("sent %0d bytes; decoded digits %0d, coords %0d, grab done %0d, grab other %0d,",
             bytes_accepted, kind_hits[0], kind_hits[1], kind_hits[2], kind_hits[3]);
    $display("unknown command %0d, with bursty input and a long output hold", kind_hits[4]);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ fixed_frame_command_decoder_core.f @@
+incdir+src
src/fcd_pkg.sv
src/fixed_frame_command_decoder_core.sv
test/fixed_frame_command_decoder_core_tb.sv
